[hw/rtl/cell_broadcast_carousel_table_defines.svh]
// assertion macros for the carousel table back end rtl
// no dependencies; expects clock and reset in the using module
`ifndef CELL_BROADCAST_CAROUSEL_TABLE_DEFINES_SVH
`define CELL_BROADCAST_CAROUSEL_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CBCT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CBCT_ASSERT_NOW(lbl, ante, cons, msg)
`define CBCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/cbct_pkg.sv]
// shared types, codes and helpers for the broadcast carousel table
// no dependencies
package cbct_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 16;
   localparam int unsigned MAX_PAGES_DEF   = 15;

   localparam logic [15:0] ALL_IDS  = 16'hffff;
   localparam logic [10:0] MAX_CODE = 11'd1023;
   localparam logic [10:0] ANY_CODE = 11'd1024;
   localparam logic [11:0] PAGE_ROUND = 12'd81;
   // floor(x / 82) as (x * 12788) >> 20, exact for x below 2^12
   localparam logic [13:0] PAGE_RECIP = 14'd12788;

   // commands
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_KILL  = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_PAGES   = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   // classified operation kinds
   localparam logic [2:0] K_REJECT    = 3'd0;
   localparam logic [2:0] K_WRITE     = 3'd1;
   localparam logic [2:0] K_KILL_ALL  = 3'd2;
   localparam logic [2:0] K_KILL_ID   = 3'd3;
   localparam logic [2:0] K_KILL_PAIR = 3'd4;
   localparam logic [2:0] K_FETCH     = 3'd5;

   typedef struct packed {
      logic [15:0] handle;
      logic [3:0]  pages;
      logic [3:0]  upd;
      logic [7:0]  coding;
      logic [1:0]  scope;
      logic [9:0]  code;
      logic [15:0] id;
   } entry_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  status;
      logic [15:0] id;
      logic [9:0]  code;
      logic [1:0]  scope;
      logic [7:0]  coding;
      logic [3:0]  pages;
      logic [15:0] handle;
   } op_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] id;
      logic [9:0]  code;
      logic [1:0]  scope;
      logic [7:0]  coding;
      logic [3:0]  upd;
      logic [3:0]  page;
      logic [3:0]  total;
      logic [15:0] handle;
      logic        last;
   } rsp_type;

   // page count of a message, (len/2 + 81) / 82
   function automatic logic [4:0] page_count(input logic [11:0] len);
      logic [11:0] x;
      logic [25:0] prod;
      x    = {1'b0, len[11:1]} + PAGE_ROUND;
      prod = x * PAGE_RECIP;
      return prod[24:20];
   endfunction

endpackage

[hw/rtl/cbct_front.sv]
// front end: channel register and command classification
// depends on cbct_pkg
module cbct_front #(
   parameter int unsigned MAX_PAGES = cbct_pkg::MAX_PAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic [1:0]       req_cmd,
   input  logic [15:0]      req_msg_id,
   input  logic [10:0]      req_msg_code,
   input  logic [1:0]       req_geo_scope,
   input  logic [7:0]       req_coding_scheme,
   input  logic [11:0]      req_text_len,
   input  logic [15:0]      req_payload_handle,
   output cbct_pkg::op_type op
);
   import cbct_pkg::*;

   logic       chan_ff;
   logic       chan_in;
   logic [4:0] pages;
   logic       bad_args;

   // channel presence register
   always_comb begin
      chan_in = csr_wr_en ? csr_wr_data : chan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 1'b1;
      end else begin
         chan_ff <= chan_in;
      end
   end

   // classify the request beat
   assign pages    = page_count(req_text_len);
   assign bad_args = (req_msg_id == ALL_IDS) || (req_msg_code > MAX_CODE) || !chan_ff ||
                     (req_text_len == 12'd0) || req_text_len[0];

   always_comb begin
      op.status = ST_OK;
      op.id     = req_msg_id;
      op.code   = req_msg_code[9:0];
      op.scope  = req_geo_scope;
      op.coding = req_coding_scheme;
      op.pages  = pages[3:0];
      op.handle = req_payload_handle;
      unique case (req_cmd)
         CMD_WRITE: begin
            if (bad_args) begin
               op.kind   = K_REJECT;
               op.status = ST_INVALID;
            end else if (pages > 5'(MAX_PAGES)) begin
               op.kind   = K_REJECT;
               op.status = ST_PAGES;
            end else begin
               op.kind = K_WRITE;
            end
         end
         CMD_KILL: begin
            if (req_msg_id == ALL_IDS) begin
               op.kind = K_KILL_ALL;
            end else if (req_msg_code >= ANY_CODE) begin
               op.kind = K_KILL_ID;
            end else begin
               op.kind = K_KILL_PAIR;
            end
         end
         CMD_FETCH: begin
            op.kind = K_FETCH;
         end
         default: begin
            op.kind   = K_REJECT;
            op.status = ST_INVALID;
         end
      endcase
   end

endmodule

[hw/rtl/cbct_queue.sv]
// two-entry queue of classified operations between front and back
// depends on cbct_pkg
module cbct_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cbct_pkg::op_type push_op,
   input  logic             pop,
   output cbct_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);
   import cbct_pkg::*;

   localparam logic [1:0] FILL_NONE = 2'd0;
   localparam logic [1:0] FILL_ONE  = 2'd1;
   localparam logic [1:0] FILL_TWO  = 2'd2;

   op_type     slot0_ff, slot0_in;
   op_type     slot1_ff, slot1_in;
   logic [1:0] fill_ff, fill_in;

   assign head_op = slot0_ff;
   assign empty   = (fill_ff == FILL_NONE);
   assign full    = (fill_ff == FILL_TWO);

   // slot shifting on push and pop
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      if (push && pop) begin
         if (fill_ff == FILL_TWO) begin
            slot0_in = slot1_ff;
            slot1_in = push_op;
         end else begin
            slot0_in = push_op;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         fill_in  = fill_ff - 2'd1;
      end else if (push) begin
         if (fill_ff == FILL_NONE) begin
            slot0_in = push_op;
         end else begin
            slot1_in = push_op;
         end
         fill_in = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_NONE;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

[hw/rtl/cbct_back.sv]
// back end: entry memory, compacting scan sequencer and result register
// depends on cbct_pkg and the assertion macro header
`include "cell_broadcast_carousel_table_defines.svh"
module cbct_back #(
   parameter int unsigned TABLE_DEPTH = cbct_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned MAX_PAGES   = cbct_pkg::MAX_PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cbct_pkg::op_type  q_op,
   output logic              q_pop,
   output cbct_pkg::rsp_type rsp,
   output logic              rsp_vld
);
   import cbct_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_PAGES  = 2'd3;

   entry_type mem [TABLE_DEPTH];

   logic [1:0]       state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_zero_ff, rd_zero_in;
   logic             found_ff, found_in;
   logic [3:0]       old_upd_ff, old_upd_in;
   entry_type        hold_ff, hold_in;
   logic [3:0]       page_ff, page_in;
   entry_type        rdata_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic             we;
   logic [IDX_W-1:0] waddr;
   entry_type        wdata;
   logic [IDX_W-1:0] raddr;
   logic             issue;
   logic             remove;
   entry_type        new_entry;
   logic [3:0]       eff_pages;

   assign rsp     = rsp_ff;
   assign rsp_vld = rsp_vld_ff;

   // entry built by a write
   always_comb begin
      new_entry.id     = op_ff.id;
      new_entry.code   = op_ff.code;
      new_entry.scope  = op_ff.scope;
      new_entry.coding = op_ff.coding;
      new_entry.pages  = op_ff.pages;
      new_entry.handle = op_ff.handle;
      new_entry.upd    = found_ff ? (old_upd_ff + 4'd1) : 4'd0;
   end

   // pages sent for a fetched entry
   always_comb begin
      if (hold_ff.pages == 4'd0) begin
         eff_pages = 4'd1;
      end else if (hold_ff.pages > 4'(MAX_PAGES)) begin
         eff_pages = 4'(MAX_PAGES);
      end else begin
         eff_pages = hold_ff.pages;
      end
   end

   assign issue = (rd_ptr_ff < count_ff);
   assign raddr = rd_ptr_ff[IDX_W-1:0];

   // which scanned entries are dropped
   always_comb begin
      remove = 1'b0;
      unique case (op_ff.kind)
         K_FETCH:   remove = rd_zero_ff;
         K_KILL_ID: remove = (rdata_ff.id == op_ff.id);
         K_WRITE, K_KILL_PAIR: begin
            remove = !found_ff && (rdata_ff.id == op_ff.id) && (rdata_ff.code == op_ff.code);
         end
         default: remove = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_vld_in  = 1'b0;
      rd_zero_in = rd_zero_ff;
      found_in   = found_ff;
      old_upd_in = old_upd_ff;
      hold_in    = hold_ff;
      page_in    = page_ff;
      rsp_in     = '0;
      rsp_vld_in = 1'b0;
      we         = 1'b0;
      waddr      = wr_ptr_ff[IDX_W-1:0];
      wdata      = rdata_ff;
      q_pop      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               op_in     = q_op;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               found_in  = 1'b0;
               rsp_in.last = 1'b1;
               if (q_op.kind == K_REJECT) begin
                  rsp_in.status = q_op.status;
                  rsp_vld_in    = 1'b1;
               end else if (q_op.kind == K_KILL_ALL) begin
                  count_in      = '0;
                  rsp_in.status = ST_OK;
                  rsp_vld_in    = 1'b1;
               end else if ((q_op.kind == K_FETCH) && (count_ff == '0)) begin
                  rsp_in.status = ST_EMPTY;
                  rsp_vld_in    = 1'b1;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read ahead, write kept entries back compacted
            rd_vld_in  = issue;
            rd_zero_in = (rd_ptr_ff == '0);
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (remove) begin
                  found_in   = 1'b1;
                  old_upd_in = rdata_ff.upd;
                  hold_in    = rdata_ff;
               end else begin
                  we        = 1'b1;
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_in.last = 1'b1;
            state_in    = S_IDLE;
            if (op_ff.kind == K_WRITE) begin
               rsp_vld_in = 1'b1;
               if (!found_ff && (wr_ptr_ff == CNT_W'(TABLE_DEPTH))) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  we            = 1'b1;
                  wdata         = new_entry;
                  count_in      = wr_ptr_ff + 1'b1;
                  rsp_in.status = ST_OK;
                  rsp_in.id     = new_entry.id;
                  rsp_in.code   = new_entry.code;
                  rsp_in.scope  = new_entry.scope;
                  rsp_in.coding = new_entry.coding;
                  rsp_in.upd    = new_entry.upd;
                  rsp_in.total  = new_entry.pages;
                  rsp_in.handle = new_entry.handle;
               end
            end else if (op_ff.kind == K_FETCH) begin
               we       = 1'b1;
               wdata    = hold_ff;
               count_in = wr_ptr_ff + 1'b1;
               page_in  = 4'd1;
               state_in = S_PAGES;
            end else begin
               count_in      = wr_ptr_ff;
               rsp_in.status = ST_OK;
               rsp_vld_in    = 1'b1;
            end
         end
         S_PAGES: begin
            rsp_vld_in    = 1'b1;
            rsp_in.status = ST_OK;
            rsp_in.id     = hold_ff.id;
            rsp_in.code   = hold_ff.code;
            rsp_in.scope  = hold_ff.scope;
            rsp_in.coding = hold_ff.coding;
            rsp_in.upd    = hold_ff.upd;
            rsp_in.page   = page_ff;
            rsp_in.total  = hold_ff.pages;
            rsp_in.handle = hold_ff.handle;
            rsp_in.last   = (page_ff == eff_pages);
            if (page_ff == eff_pages) begin
               state_in = S_IDLE;
            end else begin
               page_in = page_ff + 4'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      rd_zero_ff <= rd_zero_in;
      found_ff   <= found_in;
      old_upd_ff <= old_upd_in;
      hold_ff    <= hold_in;
      page_ff    <= page_in;
      rsp_ff     <= rsp_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   `CBCT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "count over depth")
   `CBCT_ASSERT_NOW(a_wr_behind_rd, 1'b1, wr_ptr_ff <= rd_ptr_ff, "write pointer passed read")
   `CBCT_ASSERT_NOW(a_rd_in_scan, rd_vld_ff, state_ff == S_SCAN, "read data outside scan")
   `CBCT_ASSERT_NEXT(a_page_beat, state_ff == S_PAGES, rsp_vld_ff, "page beat missing")

endmodule

[hw/rtl/cell_broadcast_carousel_table.sv]
// Broadcast message carousel table, top level.
// Depends on cbct_pkg, cbct_front, cbct_queue and cbct_back.
//
// Usage: drive req_* with start high; the command is taken at an edge where
// busy is low. Commands are write message, kill messages and fetch next.
// Each command gives rsp_* beats marked by rsp_valid for one cycle; the final
// beat of a command has rsp_last set. The receiver cannot stall: every beat
// must be taken in the cycle it appears.
// csr_wr_en/csr_wr_data write the channel present bit (reset value 1).
// Sequence: a rejected command, a kill of all entries or a fetch on an
// empty table is answered from the idle state without a scan. Writes, id
// kills and pair kills scan the table once through the entry memory. A
// fetch scans too, then adds one beat per page, up to MAX_PAGES (15) pages.
// Concurrency: one command at a time in the back end; a two-entry queue lets
// up to two further commands be taken while one is being worked on, and busy
// is high while that queue is full.
// Reset: synchronous, empties the table and the queue; the entry memory is
// not cleared, since only entries below the count are read.
module cell_broadcast_carousel_table #(
   parameter int unsigned TABLE_DEPTH = cbct_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned MAX_PAGES   = cbct_pkg::MAX_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_msg_id,
   input  logic [10:0] req_msg_code,
   input  logic [1:0]  req_geo_scope,
   input  logic [7:0]  req_coding_scheme,
   input  logic [11:0] req_text_len,
   input  logic [15:0] req_payload_handle,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [9:0]  rsp_out_code,
   output logic [1:0]  rsp_out_scope,
   output logic [7:0]  rsp_out_coding,
   output logic [3:0]  rsp_update_number,
   output logic [3:0]  rsp_page_number,
   output logic [3:0]  rsp_page_total,
   output logic [15:0] rsp_out_handle,
   output logic        rsp_last
);
   import cbct_pkg::*;

   op_type  front_op;
   op_type  head_op;
   rsp_type rsp;
   logic    q_empty;
   logic    q_full;
   logic    q_pop;

   assign busy = q_full;

   cbct_front #(
      .MAX_PAGES(MAX_PAGES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req_cmd),
      .req_msg_id         (req_msg_id),
      .req_msg_code       (req_msg_code),
      .req_geo_scope      (req_geo_scope),
      .req_coding_scheme  (req_coding_scheme),
      .req_text_len       (req_text_len),
      .req_payload_handle (req_payload_handle),
      .op                 (front_op)
   );

   cbct_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (start && !q_full),
      .push_op (front_op),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   cbct_back #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_PAGES  (MAX_PAGES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_op    (head_op),
      .q_pop   (q_pop),
      .rsp     (rsp),
      .rsp_vld (rsp_valid)
   );

   // result beat fields
   assign rsp_status        = rsp.status;
   assign rsp_out_id        = rsp.id;
   assign rsp_out_code      = rsp.code;
   assign rsp_out_scope     = rsp.scope;
   assign rsp_out_coding    = rsp.coding;
   assign rsp_update_number = rsp.upd;
   assign rsp_page_number   = rsp.page;
   assign rsp_page_total    = rsp.total;
   assign rsp_out_handle    = rsp.handle;
   assign rsp_last          = rsp.last;

endmodule
